// ===== rtl/saclru_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// saclru_pkg
// Shared sizes, register indexes and line layout for the set-associative
// LRU cache tracker.
// ----------------------------------------------------------------------------
package saclru_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;

	localparam int SET_COUNT  = 1 << MAX_SET_BITS;
	localparam int LINE_COUNT = SET_COUNT * MAX_WAYS;

	localparam int ADDR_W   = 64;
	localparam int TAG_W    = 62;
	localparam int AGE_W    = 32;
	localparam int CNT_W    = 32;
	localparam int SET_W    = MAX_SET_BITS;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_CW   = $clog2(MAX_WAYS + 1);
	localparam int LADDR_W  = $clog2(LINE_COUNT);
	localparam int SEFF_W   = $clog2(MAX_SET_BITS + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int SETB_W     = 3;
	localparam int BLKB_W     = 6;
	localparam int WAYS_W     = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	// one stored line
	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} line_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/set_assoc_cache_lru_sim_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top
// Set-associative cache hit/miss tracker with LRU replacement, one address
// per beat, one result beat per address with running saturating counts.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | in_valid / in_stall       | address
//  out      | out_valid / out_stall     | was_hit, was_eviction, hit_count,
//           |                           | miss_count, eviction_count
//  cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
//  an item runs prep, then a read and an update step for each of the W ways in
//  use, then fill and done; the first access to a set after reset walks all MAX_WAYS ways
//  the walk goes one way at a time through the line memory (one read port and
//  one write port): a read step, then a step to age, compare and write it back
//  reset clears control state and per-set valid bits; line memory has no reset,
//  a set whose valid bit is clear reads as all-zero lines
//  in_stall is high whenever an item is in flight; a stalled result holds
//  in its output register and blocks only the finish step of the next item
//
module set_assoc_cache_lru_sim_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [saclru_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [saclru_pkg::CFG_DATA_W-1:0] cfg_data,
	// input beats
	input  wire logic                             in_valid,
	output      logic                             in_stall,
	input  wire logic [saclru_pkg::ADDR_W-1:0]    address,
	// result beats
	output      logic                             out_valid,
	input  wire logic                             out_stall,
	output      logic                             was_hit,
	output      logic                             was_eviction,
	output      logic [saclru_pkg::CNT_W-1:0]     hit_count,
	output      logic [saclru_pkg::CNT_W-1:0]     miss_count,
	output      logic [saclru_pkg::CNT_W-1:0]     eviction_count
);
	import saclru_pkg::*;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;  // split address into set and tag
	localparam logic [2:0] ST_READ = 3'd2;  // read one way
	localparam logic [2:0] ST_UPD  = 3'd3;  // age, compare, write back
	localparam logic [2:0] ST_FILL = 3'd4;  // miss: fill or replace
	localparam logic [2:0] ST_DONE = 3'd5;  // counters and result beat

	logic [2:0] state_q;

	// configuration registers
	logic [SETB_W-1:0] set_bits_q;
	logic [BLKB_W-1:0] block_bits_q;
	logic [WAYS_W-1:0] ways_in_use_q;

	// item in flight
	logic [ADDR_W-1:0] addr_q;
	logic [SET_W-1:0]  set_q;
	logic [TAG_W-1:0]  tag_q;
	logic [WAY_CW-1:0] way_q;
	logic [WAY_CW-1:0] walk_n_q;
	logic              row_ok_q;
	logic              hit_q;
	logic              inv_found_q;
	logic [WAY_W-1:0]  inv_way_q;
	logic [WAY_W-1:0]  vic_way_q;
	logic [AGE_W-1:0]  vic_age_q;

	// per-set valid bits; a clear bit means the whole row is still at reset
	logic [SET_COUNT-1:0] set_valid_q;

	// line memory, one entry per way of each set
	line_t            line_mem_q [LINE_COUNT];
	line_t            rd_q;
	logic             mem_we;
	logic [LADDR_W-1:0] mem_waddr;
	logic [LADDR_W-1:0] mem_raddr;
	line_t            mem_wdata;

	// totals and result register
	logic [CNT_W-1:0] hits_total_q;
	logic [CNT_W-1:0] misses_total_q;
	logic [CNT_W-1:0] evictions_total_q;
	logic             out_valid_q;
	logic             was_hit_q;
	logic             was_eviction_q;
	logic [CNT_W-1:0] hit_count_q;
	logic [CNT_W-1:0] miss_count_q;
	logic [CNT_W-1:0] eviction_count_q;

	// clamped configuration
	logic [SEFF_W-1:0] s_eff;
	logic [BLKB_W-1:0] b_eff;
	logic [WAY_CW-1:0] e_eff;
	logic [BLKB_W:0]   tag_shift;
	logic [SET_W-1:0]  set_mask;
	logic [ADDR_W-1:0] addr_blk;
	logic [SET_W-1:0]  set_calc;
	logic [TAG_W-1:0]  tag_calc;

	// per-way update
	line_t            cur_line;
	logic             way_active;
	logic             way_match;
	logic [AGE_W-1:0] age_new;
	logic             last_way;
	logic [WAY_W-1:0] way_idx;
	logic             out_free;
	logic             item_miss;
	logic             item_evict;

	always_comb begin
		if (set_bits_q == '0)
			s_eff = SEFF_W'(1);
		else if (int'(set_bits_q) > MAX_SET_BITS)
			s_eff = SEFF_W'(MAX_SET_BITS);
		else
			s_eff = SEFF_W'(set_bits_q);

		b_eff = (block_bits_q == '0) ? BLKB_W'(1) : block_bits_q;

		if (ways_in_use_q == '0)
			e_eff = WAY_CW'(1);
		else if (int'(ways_in_use_q) > MAX_WAYS)
			e_eff = WAY_CW'(MAX_WAYS);
		else
			e_eff = WAY_CW'(ways_in_use_q);
	end

	// address split: two barrel shifts, used in the prep cycle only
	assign tag_shift = (BLKB_W + 1)'(s_eff) + (BLKB_W + 1)'(b_eff);
	assign set_mask  = ~({SET_W{1'b1}} << s_eff);
	assign addr_blk  = addr_q >> b_eff;
	assign set_calc  = addr_blk[SET_W-1:0] & set_mask;
	assign tag_calc  = (int'(tag_shift) >= ADDR_W) ? '0 : TAG_W'(addr_q >> tag_shift);

	// one way per visit: saturating age, tag compare, victim tracking
	assign way_idx    = way_q[WAY_W-1:0];
	assign cur_line   = row_ok_q ? rd_q : '0;
	assign way_active = (way_q < e_eff);
	assign way_match  = cur_line.valid && (cur_line.tag == tag_q);
	assign age_new    = way_match ? '0 : sat_inc(cur_line.age);
	assign last_way   = (way_q + WAY_CW'(1)) >= walk_n_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign item_miss  = !hit_q;
	assign item_evict = !hit_q && !inv_found_q;

	// memory port control
	assign mem_raddr = {set_q, way_idx};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {set_q, way_idx};
		mem_wdata = '0;
		unique case (state_q)
			ST_UPD: begin
				mem_we = 1'b1;
				if (way_active) begin
					mem_wdata.valid = cur_line.valid;
					mem_wdata.tag   = cur_line.tag;
					mem_wdata.age   = age_new;
				end
			end
			ST_FILL: begin
				mem_we          = item_miss;
				mem_waddr       = {set_q, (inv_found_q ? inv_way_q : vic_way_q)};
				mem_wdata.valid = 1'b1;
				mem_wdata.tag   = tag_q;
				mem_wdata.age   = '0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem_q[mem_waddr] <= mem_wdata;
		rd_q <= line_mem_q[mem_raddr];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= SETB_W'(1);
			block_bits_q  <= BLKB_W'(1);
			ways_in_use_q <= WAYS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:    set_bits_q    <= cfg_data[SETB_W-1:0];
				CFG_BLOCK_BITS:  block_bits_q  <= cfg_data[BLKB_W-1:0];
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data[WAYS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			set_valid_q       <= '0;
			hits_total_q      <= '0;
			misses_total_q    <= '0;
			evictions_total_q <= '0;
			out_valid_q       <= 1'b0;
			way_q             <= '0;
			walk_n_q          <= '0;
			row_ok_q          <= 1'b0;
			hit_q             <= 1'b0;
			inv_found_q       <= 1'b0;
		end else begin
			// a new result beat replaces the one leaving this cycle
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					way_q       <= '0;
					row_ok_q    <= set_valid_q[set_calc];
					// an untouched row is walked in full so every way is written and none keeps stale contents
					walk_n_q    <= set_valid_q[set_calc] ? e_eff : WAY_CW'(MAX_WAYS);
					hit_q       <= 1'b0;
					inv_found_q <= 1'b0;
					state_q     <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (way_active) begin
						if (way_match)
							hit_q <= 1'b1;
						if (!cur_line.valid && !inv_found_q)
							inv_found_q <= 1'b1;
					end
					way_q   <= way_q + WAY_CW'(1);
					state_q <= last_way ? ST_FILL : ST_READ;
				end
				ST_FILL: begin
					set_valid_q[set_q] <= 1'b1;
					state_q            <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						if (hit_q)
							hits_total_q <= sat_inc(hits_total_q);
						if (item_miss)
							misses_total_q <= sat_inc(misses_total_q);
						if (item_evict)
							evictions_total_q <= sat_inc(evictions_total_q);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			addr_q <= address;
		if (state_q == ST_PREP) begin
			set_q <= set_calc;
			tag_q <= tag_calc;
		end
		if (state_q == ST_UPD && way_active) begin
			if (!cur_line.valid && !inv_found_q)
				inv_way_q <= way_idx;
			// strict compare keeps the lowest way on a tie
			if (way_q == '0 || age_new > vic_age_q) begin
				vic_way_q <= way_idx;
				vic_age_q <= age_new;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			was_hit_q        <= hit_q;
			was_eviction_q   <= item_evict;
			hit_count_q      <= hit_q ? sat_inc(hits_total_q) : hits_total_q;
			miss_count_q     <= item_miss ? sat_inc(misses_total_q) : misses_total_q;
			eviction_count_q <= item_evict ? sat_inc(evictions_total_q) : evictions_total_q;
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign was_hit        = was_hit_q;
	assign was_eviction   = was_eviction_q;
	assign hit_count      = hit_count_q;
	assign miss_count     = miss_count_q;
	assign eviction_count = eviction_count_q;

	// checks
	a_mem_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_UPD || state_q == ST_FILL))
		else $error("line memory written outside the walk or fill step");

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_PREP))
		else $error("accepted beat did not start the sequencer");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (way_q < walk_n_q))
		else $error("way walk ran past its end");

	a_hit_excl_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(was_hit_q && was_eviction_q))
		else $error("result marks both hit and eviction");

	a_evict_le_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (eviction_count_q <= miss_count_q))
		else $error("eviction count passed miss count");

endmodule

`default_nettype wire
